>>> rtl/core/svd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svd_pkg
// Shared types, constants and helper functions of the stereo vibrato delay.
// ---------------------------------------------------------------------------
package svd_pkg;

    // fixed number formats
    localparam int SAMPLE_BITS   = 24;
    localparam int PHASE_BITS    = 24;
    localparam int AIR_BITS      = 32;
    localparam int SINE_IDX_BITS = 10;
    localparam int QTR_DEPTH     = 256;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;

    // filter and interpolation constants
    localparam logic signed [17:0] LEAK_K      = 18'sd107363;
    localparam logic signed [19:0] CURVE_K     = 20'sd335544;
    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [15:0] WET_ONLY    = 16'sd32767;

    // register indexes
    localparam logic [2:0] REG_LFO_STEP    = 3'd0;
    localparam logic [2:0] REG_DELAY_DEPTH = 3'd1;
    localparam logic [2:0] REG_FM_STEP     = 3'd2;
    localparam logic [2:0] REG_FM_AMOUNT   = 3'd3;
    localparam logic [2:0] REG_WET_LEVEL   = 3'd4;

    // register reset values
    localparam logic [23:0]        RST_LFO_STEP    = 24'd10937;
    localparam logic [19:0]        RST_DELAY_DEPTH = 20'd0;
    localparam logic [23:0]        RST_FM_STEP     = 24'd41721;
    localparam logic [23:0]        RST_FM_AMOUNT   = 24'd0;
    localparam logic signed [15:0] RST_WET_LEVEL   = 16'sd32767;

    typedef struct packed {
        logic [23:0]        lfo_step;
        logic [19:0]        delay_depth;
        logic [23:0]        fm_step;
        logic [23:0]        fm_amount;
        logic signed [15:0] wet_level;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_AIR1,
        ST_AIR2,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_INT,
        ST_MIX1,
        ST_MIX2,
        ST_FIN
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic       load;
        logic       air1;
        logic       air2;
        logic       air3;
        logic [1:0] rd_tap;
        logic       cap_a;
        logic       cap_b;
        logic       intp;
        logic       mix1;
        logic       mix2;
        logic       fin;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_stat;

    typedef logic [23:0] t_sine_tbl [QTR_DEPTH];

    // saturate to the air accumulator width
    function automatic logic signed [31:0] sat_air(input logic signed [39:0] x);
        if (x > 40'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -40'sd2147483648) return 32'sh80000000;
        return 32'(x);
    endfunction

    // saturate to the sample width
    function automatic logic signed [23:0] sat_smp(input logic signed [39:0] x);
        if (x > 40'sd8388607) return 24'sh7FFFFF;
        if (x < -40'sd8388608) return 24'sh800000;
        return 24'(x);
    endfunction

    // sine magnitude in Q23 for quarter-wave position m of 256
    function automatic logic [23:0] sine_mag(input int unsigned m);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic signed [63:0] v;
        x    = ((64'(m) * 64'd4) * HALF_PI_Q30 + 64'd512) >> 10;
        x2   = (x * x) >> 30;
        term = x;
        sum  = signed'(x);
        for (int k = 1; k <= 5; k++) begin
            term = (term * x2) >> 30;
            case (k)
                1:       term = term / 64'd6;
                2:       term = term / 64'd20;
                3:       term = term / 64'd42;
                4:       term = term / 64'd72;
                default: term = term / 64'd110;
            endcase
            if ((k & 1) == 1) sum = sum - signed'(term);
            else              sum = sum + signed'(term);
        end
        v = (sum + 64'sd64) >>> 7;
        if (v < 0) v = 0;
        if (v > 64'sd8388608) v = 64'sd8388608;
        return 24'(v);
    endfunction

    function automatic t_sine_tbl build_sine();
        t_sine_tbl t;
        for (int i = 0; i < QTR_DEPTH; i++) t[i] = sine_mag(i);
        return t;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/svd_in_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svd_in_if
// Stereo input channel: valid/ready handshake with one sample pair.
// ---------------------------------------------------------------------------
interface svd_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface
`default_nettype wire

>>> rtl/core/svd_out_if.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svd_out_if
// Stereo output channel: valid/ready handshake with one sample pair.
// ---------------------------------------------------------------------------
interface svd_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface
`default_nettype wire

>>> rtl/core/stereo_vibrato_delay.sv
`default_nettype none
// ---------------------------------------------------------------------------
// stereo_vibrato_delay
// Stereo LFO-modulated vibrato delay with air pre-emphasis and wet/dry mix.
// ---------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  i_in      in         valid / ready      left_in, right_in (s24)
//  o_out     out        valid / ready      left_out, right_out (s24)
//  apb       in         psel/penable/...   5 registers at byte address 4*i
//
//  the sequencer steps one sample pair through accept, air filter in two multiply
//  steps, three registered reads of the single-read-port delay memories,
//  interpolation, mix in two multiply steps and result load.
//  a pair is accepted only while the sequencer is idle.
//  a result waits in the output register; a stalled output holds the next pair
//  at its last step. reset is synchronous; never-written delay entries read as
//  zero through a fill count, so there is no clearing pass after reset.
// ---------------------------------------------------------------------------
module stereo_vibrato_delay #(
    parameter int DELAY_LENGTH = 8192
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    svd_in_if.sink                          i_in,
    svd_out_if.source                       o_out,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [svd_pkg::APB_AW-1:0] paddr,
    input  wire logic [svd_pkg::APB_DW-1:0] pwdata,
    output logic      [svd_pkg::APB_DW-1:0] prdata,
    output logic                            pready
);

    svd_pkg::t_cfg  w_cfg;
    svd_pkg::t_cmd  w_cmd;
    svd_pkg::t_stat w_stat;
    logic           w_in_ready;

    assign i_in.ready = w_in_ready;

    // configuration registers
    svd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // sequencer
    svd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // datapath
    svd_dp #(
        .DELAY_LENGTH (DELAY_LENGTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_left_in   (i_in.left_in),
        .i_right_in  (i_in.right_in),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_left_out  (o_out.left_out),
        .o_right_out (o_out.right_out)
    );

endmodule
`default_nettype wire

>>> rtl/core/svd_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svd_regs
// APB configuration registers of the stereo vibrato delay.
// ---------------------------------------------------------------------------
module svd_regs (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [svd_pkg::APB_AW-1:0] paddr,
    input  wire logic [svd_pkg::APB_DW-1:0] pwdata,
    output logic      [svd_pkg::APB_DW-1:0] prdata,
    output logic                           pready,
    output svd_pkg::t_cfg                  o_cfg
);

    svd_pkg::t_cfg r_cfg;
    logic          w_wr;
    logic [2:0]    w_idx;

    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lfo_step    <= svd_pkg::RST_LFO_STEP;
            r_cfg.delay_depth <= svd_pkg::RST_DELAY_DEPTH;
            r_cfg.fm_step     <= svd_pkg::RST_FM_STEP;
            r_cfg.fm_amount   <= svd_pkg::RST_FM_AMOUNT;
            r_cfg.wet_level   <= svd_pkg::RST_WET_LEVEL;
        end else if (w_wr) begin
            case (w_idx)
                svd_pkg::REG_LFO_STEP:    r_cfg.lfo_step    <= pwdata[23:0];
                svd_pkg::REG_DELAY_DEPTH: r_cfg.delay_depth <= pwdata[19:0];
                svd_pkg::REG_FM_STEP:     r_cfg.fm_step     <= pwdata[23:0];
                svd_pkg::REG_FM_AMOUNT:   r_cfg.fm_amount   <= pwdata[23:0];
                svd_pkg::REG_WET_LEVEL:   r_cfg.wet_level   <= signed'(pwdata[15:0]);
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        case (w_idx)
            svd_pkg::REG_LFO_STEP:    prdata = {8'd0, r_cfg.lfo_step};
            svd_pkg::REG_DELAY_DEPTH: prdata = {12'd0, r_cfg.delay_depth};
            svd_pkg::REG_FM_STEP:     prdata = {8'd0, r_cfg.fm_step};
            svd_pkg::REG_FM_AMOUNT:   prdata = {8'd0, r_cfg.fm_amount};
            svd_pkg::REG_WET_LEVEL:   prdata = {16'd0, r_cfg.wet_level};
            default:                  prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/svd_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svd_ctrl
// Sequencer that steps one sample pair through the datapath.
// ---------------------------------------------------------------------------
module svd_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire svd_pkg::t_stat i_stat,
    output svd_pkg::t_cmd       o_cmd
);

    svd_pkg::t_state r_state;
    svd_pkg::t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= svd_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            svd_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = svd_pkg::ST_AIR1;
                end
            end
            svd_pkg::ST_AIR1: begin
                o_cmd.air1 = 1'b1;
                n_state    = svd_pkg::ST_AIR2;
            end
            svd_pkg::ST_AIR2: begin
                o_cmd.air2 = 1'b1;
                n_state    = svd_pkg::ST_RD0;
            end
            svd_pkg::ST_RD0: begin
                o_cmd.air3   = 1'b1;
                o_cmd.rd_tap = 2'd0;
                n_state      = svd_pkg::ST_RD1;
            end
            svd_pkg::ST_RD1: begin
                o_cmd.rd_tap = 2'd1;
                o_cmd.cap_a  = 1'b1;
                n_state      = svd_pkg::ST_RD2;
            end
            svd_pkg::ST_RD2: begin
                o_cmd.rd_tap = 2'd2;
                o_cmd.cap_b  = 1'b1;
                n_state      = svd_pkg::ST_INT;
            end
            svd_pkg::ST_INT: begin
                o_cmd.intp = 1'b1;
                n_state    = svd_pkg::ST_MIX1;
            end
            svd_pkg::ST_MIX1: begin
                o_cmd.mix1 = 1'b1;
                n_state    = svd_pkg::ST_MIX2;
            end
            svd_pkg::ST_MIX2: begin
                o_cmd.mix2 = 1'b1;
                n_state    = svd_pkg::ST_FIN;
            end
            svd_pkg::ST_FIN: begin
                // hold until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = svd_pkg::ST_IDLE;
                end
            end
            default: n_state = svd_pkg::ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/core/svd_dp.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svd_dp
// Datapath: air pre-emphasis, ring delay memories, LFOs, interpolation, mix.
// ---------------------------------------------------------------------------
module svd_dp #(
    parameter int DELAY_LENGTH = 8192
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire svd_pkg::t_cfg      i_cfg,
    input  wire svd_pkg::t_cmd      i_cmd,
    output svd_pkg::t_stat          o_stat,
    input  wire logic signed [23:0] i_left_in,
    input  wire logic signed [23:0] i_right_in,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic signed [23:0]      o_left_out,
    output logic signed [23:0]      o_right_out
);

    localparam int AW = $clog2(DELAY_LENGTH);
    localparam int PB = svd_pkg::PHASE_BITS;
    localparam logic signed [24:0] MAX_OFF = 25'((DELAY_LENGTH - 3) * 256);
    localparam logic [AW:0] LEN = (AW + 1)'(DELAY_LENGTH);
    localparam svd_pkg::t_sine_tbl SINE_TBL = svd_pkg::build_sine();
    localparam logic [23:0] SINE_PEAK = svd_pkg::sine_mag(256);

    // signed Q23 sine of a phase, quarter-wave folded table
    function automatic logic signed [24:0] sine_val(input logic [PB-1:0] ph);
        logic [svd_pkg::SINE_IDX_BITS-1:0] idx;
        logic [8:0]                        m;
        logic [23:0]                       mag;
        idx = ph[PB-1 -: svd_pkg::SINE_IDX_BITS];
        m   = idx[8] ? 9'(9'd256 - {1'b0, idx[7:0]}) : {1'b0, idx[7:0]};
        mag = m[8] ? SINE_PEAK : SINE_TBL[m[7:0]];
        return idx[9] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
    endfunction

    // delay memories
    logic signed [23:0] r_mem_l [DELAY_LENGTH];
    logic signed [23:0] r_mem_r [DELAY_LENGTH];
    logic signed [23:0] r_ql;
    logic signed [23:0] r_qr;
    logic               r_qz;

    // persistent state
    logic [AW-1:0]      r_wpos;
    logic [AW:0]        r_fill;
    logic [PB-1:0]      r_main_ph;
    logic [PB-1:0]      r_mod_ph;
    logic               r_tog;
    logic signed [23:0] r_prev [2];
    logic signed [31:0] r_even [2];
    logic signed [31:0] r_odd  [2];

    // per-item working registers
    logic signed [23:0] r_in   [2];
    logic signed [33:0] r_ot   [2];
    logic signed [51:0] r_po   [2];
    logic signed [31:0] r_e1   [2];
    logic signed [33:0] r_et   [2];
    logic signed [51:0] r_pe   [2];
    logic signed [23:0] r_wl   [2];
    logic signed [23:0] r_a    [2];
    logic signed [23:0] r_b    [2];
    logic signed [33:0] r_pa   [2];
    logic signed [33:0] r_pc   [2];
    logic signed [47:0] r_pk   [2];
    logic signed [23:0] r_y    [2];
    logic signed [41:0] r_pdry [2];
    logic signed [39:0] r_pwet [2];
    logic signed [45:0] r_pd;
    logic signed [49:0] r_pf;
    logic [AW-1:0]      r_n;
    logic [7:0]         r_frac;
    logic               r_out_valid;
    logic signed [23:0] r_out [2];

    // combinational terms
    logic signed [33:0] w_ot   [2];
    logic signed [31:0] w_e1   [2];
    logic signed [23:0] w_wl   [2];
    logic signed [31:0] w_onew [2];
    logic signed [33:0] w_et   [2];
    logic signed [31:0] w_enew [2];
    logic signed [23:0] w_tap  [2];
    logic signed [23:0] w_y    [2];
    logic signed [23:0] w_mix  [2];
    logic signed [24:0] w_off;
    logic signed [24:0] w_offc;
    logic signed [26:0] w_dev;
    logic [AW:0]        w_rsum;
    logic [AW-1:0]      w_raddr;
    logic               w_rzero;
    logic signed [17:0] w_gain;
    logic signed [9:0]  w_wc;
    logic signed [9:0]  w_wa;

    assign o_stat.out_free = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_left_out      = r_out[0];
    assign o_right_out     = r_out[1];
    assign w_tap[0]        = r_qz ? 24'sd0 : r_ql;
    assign w_tap[1]        = r_qz ? 24'sd0 : r_qr;
    assign w_wc            = signed'({2'b00, r_frac});
    assign w_wa            = 10'sd256 - w_wc;

    // air filter, interpolation and mix terms per channel
    always_comb begin
        logic signed [24:0] f;
        logic signed [32:0] ep, em, op, om;
        logic signed [31:0] o1, fsel;
        logic signed [33:0] dx, dx2;
        logic signed [36:0] t;
        for (int ch = 0; ch < 2; ch++) begin
            f  = 25'(r_prev[ch]) - 25'(r_in[ch]);
            ep = 33'(r_even[ch]) + 33'(f);
            em = 33'(r_even[ch]) - 33'(f);
            op = 33'(r_odd[ch]) + 33'(f);
            om = 33'(r_odd[ch]) - 33'(f);
            if (r_tog) begin
                w_e1[ch] = svd_pkg::sat_air(40'(ep));
                o1       = svd_pkg::sat_air(40'(om));
                fsel     = w_e1[ch];
            end else begin
                w_e1[ch] = svd_pkg::sat_air(40'(em));
                o1       = svd_pkg::sat_air(40'(op));
                fsel     = o1;
            end
            w_wl[ch] = svd_pkg::sat_smp(40'(33'(r_in[ch]) + 33'(fsel)));
            dx       = 34'(o1) - 34'(w_e1[ch]) + 34'sd128;
            w_ot[ch] = 34'(o1) - (dx >>> 8);

            w_onew[ch] = svd_pkg::sat_air(40'(35'(r_ot[ch])
                         - 35'((r_po[ch] + 52'sd536870912) >>> 30)));
            dx2        = 34'(r_e1[ch]) - 34'(w_onew[ch]) + 34'sd128;
            w_et[ch]   = 34'(r_e1[ch]) - (dx2 >>> 8);
            w_enew[ch] = svd_pkg::sat_air(40'(35'(r_et[ch])
                         - 35'((r_pe[ch] + 52'sd536870912) >>> 30)));

            t = 37'(r_pa[ch]) + (37'(r_b[ch]) <<< 8) + 37'(r_pc[ch])
                - 37'((r_pk[ch] + 48'sd32768) >>> 16);
            w_y[ch]   = svd_pkg::sat_smp(40'((t + 37'sd256) >>> 9));
            w_mix[ch] = svd_pkg::sat_smp(40'((43'(r_pwet[ch]) + 43'(r_pdry[ch])
                        + 43'sd16384) >>> 15));
        end
    end

    // offset, phase deviation, dry gain
    always_comb begin
        logic signed [17:0] w18;
        w_off = 25'(signed'({1'b0, i_cfg.delay_depth}))
              + 25'((r_pd + 46'sd4194304) >>> 23);
        if (w_off < 0)            w_offc = '0;
        else if (w_off > MAX_OFF) w_offc = MAX_OFF;
        else                      w_offc = w_off;
        w_dev  = 27'((r_pf + 50'sd4194304) >>> 23);
        w18    = 18'(i_cfg.wet_level);
        w_gain = 18'sd32768 - (w18 < 0 ? -w18 : w18);
    end

    // tap address with wrap, and never-written taps read as zero
    always_comb begin
        w_rsum  = (AW + 1)'(r_wpos) + (AW + 1)'(r_n) + (AW + 1)'(i_cmd.rd_tap);
        w_raddr = (w_rsum >= LEN) ? AW'(w_rsum - LEN) : AW'(w_rsum);
        w_rzero = ((AW + 1)'(r_n) + (AW + 1)'(i_cmd.rd_tap)) >= r_fill;
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.air2) begin
            r_mem_l[r_wpos] <= r_wl[0];
            r_mem_r[r_wpos] <= r_wl[1];
        end
        r_ql <= r_mem_l[w_raddr];
        r_qr <= r_mem_r[w_raddr];
        r_qz <= w_rzero;
    end

    // persistent state updates
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos      <= '0;
            r_fill      <= '0;
            r_main_ph   <= PB'(1) << (PB - 2);
            r_mod_ph    <= PB'(1) << (PB - 2);
            r_tog       <= 1'b0;
            r_out_valid <= 1'b0;
            for (int ch = 0; ch < 2; ch++) begin
                r_prev[ch] <= '0;
                r_even[ch] <= '0;
                r_odd[ch]  <= '0;
            end
        end else begin
            if (i_cmd.air1) begin
                for (int ch = 0; ch < 2; ch++) r_prev[ch] <= r_in[ch];
            end
            if (i_cmd.air2) begin
                for (int ch = 0; ch < 2; ch++) r_odd[ch] <= w_onew[ch];
                r_main_ph <= r_main_ph + i_cfg.lfo_step + PB'(w_dev);
                r_mod_ph  <= r_mod_ph + i_cfg.fm_step;
                if (r_fill != LEN) r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.air3) begin
                for (int ch = 0; ch < 2; ch++) r_even[ch] <= w_enew[ch];
            end
            if (i_cmd.fin) begin
                r_tog  <= !r_tog;
                r_wpos <= (r_wpos == '0) ? AW'(DELAY_LENGTH - 1) : r_wpos - 1'b1;
            end
            // output register
            if (i_cmd.fin)                   r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready) r_out_valid <= 1'b0;
        end
    end

    // per-item working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in[0] <= i_left_in;
            r_in[1] <= i_right_in;
        end
        if (i_cmd.air1) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_ot[ch] <= w_ot[ch];
                r_po[ch] <= 52'(w_ot[ch]) * 52'(svd_pkg::LEAK_K);
                r_e1[ch] <= w_e1[ch];
                r_wl[ch] <= w_wl[ch];
            end
            r_pd <= 46'(signed'({1'b0, i_cfg.delay_depth})) * 46'(sine_val(r_main_ph));
            r_pf <= 50'(signed'({1'b0, i_cfg.fm_amount})) * 50'(sine_val(r_mod_ph));
        end
        if (i_cmd.air2) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_et[ch] <= w_et[ch];
                r_pe[ch] <= 52'(w_et[ch]) * 52'(svd_pkg::LEAK_K);
            end
            r_n    <= w_offc[AW+7:8];
            r_frac <= w_offc[7:0];
        end
        if (i_cmd.cap_a) begin
            for (int ch = 0; ch < 2; ch++) r_a[ch] <= w_tap[ch];
        end
        if (i_cmd.cap_b) begin
            for (int ch = 0; ch < 2; ch++) r_b[ch] <= w_tap[ch];
        end
        if (i_cmd.intp) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_pa[ch] <= 34'(r_a[ch]) * 34'(w_wa);
                r_pc[ch] <= 34'(w_tap[ch]) * 34'(w_wc);
                r_pk[ch] <= 48'(27'(r_a[ch]) - (27'(r_b[ch]) <<< 1) + 27'(w_tap[ch]))
                            * 48'(svd_pkg::CURVE_K);
            end
        end
        if (i_cmd.mix1) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_y[ch]    <= w_y[ch];
                r_pdry[ch] <= 42'(r_in[ch]) * 42'(w_gain);
            end
        end
        if (i_cmd.mix2) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_pwet[ch] <= 40'(r_y[ch]) * 40'(i_cfg.wet_level);
            end
        end
        if (i_cmd.fin) begin
            for (int ch = 0; ch < 2; ch++) begin
                r_out[ch] <= (i_cfg.wet_level == svd_pkg::WET_ONLY) ? r_y[ch] : w_mix[ch];
            end
        end
    end

endmodule
`default_nettype wire

>>> rtl/core/svd_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svd_checker
// Port-level checks of the stereo vibrato delay, bound to the top level.
// ---------------------------------------------------------------------------
module svd_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [23:0] i_out_left,
    input wire logic [23:0] i_out_right
);

    // a pending result stays offered until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output valid dropped before transaction");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_left) && $stable(i_out_right))
        else $error("output payload changed while stalled");

    // one pair at a time: no second transaction right after one
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted while a pair is in flight");

    // a result is not offered right after its input transaction
    a_no_early_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !$rose(i_out_valid))
        else $error("result appeared right after input transaction");

endmodule

bind stereo_vibrato_delay svd_checker u_svd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_left  (o_out.left_out),
    .i_out_right (o_out.right_out)
);
`default_nettype wire
